/* hdl/ilid_pkg.sv */
// Package: shared types and codes for the indexed list block.
`default_nettype none
package ilid_pkg;

  localparam int POS_W   = 9;
  localparam int CAP_W   = 9;
  localparam int CNT_O_W = 9;
  localparam int VAL_W   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_EDIT   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADIDX = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic [2:0]              operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_O_W-1:0]      item_count;
  } out_word_t;

endpackage
`default_nettype wire

/* hdl/ilid_ram.sv */
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module ilid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hdl/ilid_seq.sv */
// Sequencer: status checks, list count and the one-move-per-cycle shift loop.
`default_nettype none
module ilid_seq
  import ilid_pkg::*;
#(
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_word_t         in_word,
  output logic                  out_strobe,
  output out_word_t             out_word,
  input  wire logic [CAP_W-1:0] cap,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [VAL_W-1:0]      mem_wdata,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr,
  input  wire logic [VAL_W-1:0] mem_rdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SHIFT = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             ins_r, ins_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [AW-1:0]    last_r, last_nxt;
  logic [AW-1:0]    wa_r, wa_nxt;
  logic             pend_r, pend_nxt;
  logic             more_r, more_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_r, out_nxt;

  logic          acc;
  logic [WW-1:0] pos_w, cnt_w, lim_w, cap_w;
  logic          full, pos_le, pos_lt;
  logic [1:0]    rsp_status;
  logic          rsp;

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_valid_r;
  assign out_word   = out_r;
  assign acc        = start && (state_r == S_IDLE);

  assign pos_w  = WW'(in_word.position);
  assign cnt_w  = WW'(count_r);
  assign cap_w  = WW'(cap);
  assign lim_w  = (cap_w < WW'(DEPTH)) ? cap_w : WW'(DEPTH);
  assign full   = (cnt_w >= lim_w);
  assign pos_le = (pos_w <= cnt_w);
  assign pos_lt = (pos_w < cnt_w);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ins_nxt       = ins_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    ptr_nxt       = ptr_r;
    last_nxt      = last_r;
    wa_nxt        = wa_r;
    pend_nxt      = pend_r;
    more_nxt      = more_r;
    out_nxt       = out_r;
    rsp           = 1'b0;
    rsp_status    = ST_OK;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = val_r;
    mem_re        = 1'b0;
    mem_raddr     = ptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          pos_nxt = AW'(in_word.position);
          val_nxt = $unsigned(in_word.value);
          rsp     = 1'b1;
          case (in_word.operation) inside
            OP_APPEND: begin
              if (full) begin
                rsp_status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(count_r);
                mem_wdata = $unsigned(in_word.value);
                count_nxt = count_r + 1'b1;
              end
            end
            OP_INSERT: begin
              if (full) begin
                rsp_status = ST_FULL;
              end else if (!pos_le) begin
                rsp_status = ST_BADIDX;
              end else if (pos_w == cnt_w) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(count_r);
                mem_wdata = $unsigned(in_word.value);
                count_nxt = count_r + 1'b1;
              end else begin
                rsp       = 1'b0;
                ins_nxt   = 1'b1;
                ptr_nxt   = AW'(count_r - 1'b1);
                last_nxt  = AW'(in_word.position);
                pend_nxt  = 1'b0;
                more_nxt  = 1'b1;
                state_nxt = S_SHIFT;
              end
            end
            OP_DELETE, OP_EDIT, OP_READ: begin
              if (count_r == '0) begin
                rsp_status = ST_EMPTY;
              end else if (!pos_lt) begin
                rsp_status = ST_BADIDX;
              end else if (in_word.operation == OP_EDIT) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(in_word.position);
                mem_wdata = $unsigned(in_word.value);
              end else if (in_word.operation == OP_READ) begin
                rsp       = 1'b0;
                mem_re    = 1'b1;
                mem_raddr = AW'(in_word.position);
                state_nxt = S_READ;
              end else if (pos_w + 1'b1 == cnt_w) begin
                count_nxt = count_r - 1'b1;
              end else begin
                rsp       = 1'b0;
                ins_nxt   = 1'b0;
                ptr_nxt   = AW'(in_word.position) + 1'b1;
                last_nxt  = AW'(count_r - 1'b1);
                pend_nxt  = 1'b0;
                more_nxt  = 1'b1;
                state_nxt = S_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wa_r;
          mem_wdata = mem_rdata;
        end
        if (more_r) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_r;
          pend_nxt  = 1'b1;
          wa_nxt    = ins_r ? ptr_r + 1'b1 : ptr_r - 1'b1;
          ptr_nxt   = ins_r ? ptr_r - 1'b1 : ptr_r + 1'b1;
          more_nxt  = (ptr_r != last_r);
        end else begin
          pend_nxt = 1'b0;
        end
        if (!more_r && !pend_r) begin
          if (ins_r) begin
            mem_we    = 1'b1;
            mem_waddr = pos_r;
            mem_wdata = val_r;
            count_nxt = count_r + 1'b1;
          end else begin
            count_nxt = count_r - 1'b1;
          end
          rsp       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        rsp       = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = rsp;
    if (rsp) begin
      out_nxt.status     = rsp_status;
      out_nxt.read_value = (state_r == S_READ) ? $signed(mem_rdata) : '0;
      out_nxt.item_count = CNT_O_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      more_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      more_r      <= more_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_r  <= ins_nxt;
    pos_r  <= pos_nxt;
    val_r  <= val_nxt;
    ptr_r  <= ptr_nxt;
    last_r <= last_nxt;
    wa_r   <= wa_nxt;
    out_r  <= out_nxt;
  end

endmodule
`default_nettype wire

/* hdl/indexed_list_insert_delete.sv */
// Top level: ordered list of signed words with append, insert, delete, edit, read.
// Append, insert at the end, edit, delete of the last entry and failed or unknown
// operations: result registered in the cycle after start; read passes through S_READ
// first. Insert and delete that move entries loop in S_SHIFT, one RAM move per cycle.
// busy stays high until the result word is issued; out_strobe cannot be stalled.
// Synchronous active-low reset empties the list and sets capacity to 256.
`default_nettype none
module indexed_list_insert_delete
  import ilid_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_word_t         in_word,
  output logic                  out_strobe,
  output out_word_t             out_word,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CAP_W-1:0] cap_r;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [VAL_W-1:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  ilid_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word),
    .cap       (cap_r),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ilid_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule
`default_nettype wire

/* tb/ilid_checker.sv */
// Checker: predicts list results from accepted words and compares them with the block's output.
`timescale 1ns / 1ps
module ilid_checker
  import ilid_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  in_word_t         in_word,
  input  logic             out_strobe,
  input  out_word_t        out_word,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  output int               mismatches,
  output int               pending,
  output int               list_len
);

  logic signed [VAL_W-1:0] list_store [DEPTH];
  logic [CAP_W-1:0]        list_cap;
  out_word_t               expected_results [$];
  out_word_t               want;

  function automatic out_word_t apply_list_op(input in_word_t w);
    out_word_t r;
    int        lim;
    int        p;
    logic      full;
    r        = '0;
    r.status = ST_OK;
    lim      = (list_cap < DEPTH) ? int'(list_cap) : DEPTH;
    full     = (list_len >= lim);
    p        = int'(w.position);
    case (w.operation) inside
      OP_APPEND: begin
        if (full) begin
          r.status = ST_FULL;
        end else begin
          list_store[list_len] = w.value;
          list_len++;
        end
      end
      OP_INSERT: begin
        if (full) begin
          r.status = ST_FULL;
        end else if (p > list_len) begin
          r.status = ST_BADIDX;
        end else begin
          for (int i = list_len; i > p; i--) list_store[i] = list_store[i-1];
          list_store[p] = w.value;
          list_len++;
        end
      end
      OP_DELETE, OP_EDIT, OP_READ: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= list_len) begin
          r.status = ST_BADIDX;
        end else if (w.operation == OP_DELETE) begin
          for (int i = p; i + 1 < list_len; i++) list_store[i] = list_store[i+1];
          list_len--;
        end else if (w.operation == OP_EDIT) begin
          list_store[p] = w.value;
        end else begin
          r.read_value = list_store[p];
        end
      end
      default: ;
    endcase
    r.item_count = list_len[CNT_O_W-1:0];
    return r;
  endfunction

  task automatic report(input string what, input out_word_t exp_w, input out_word_t got_w);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: exp status=%0d read=%0d count=%0d, got status=%0d read=%0d count=%0d",
               $time, what, exp_w.status, exp_w.read_value, exp_w.item_count,
               got_w.status, got_w.read_value, got_w.item_count);
  endtask

  initial begin
    mismatches = 0;
    pending    = 0;
    list_len   = 0;
    list_cap   = CAP_RESET;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      list_len = 0;
      list_cap = CAP_RESET;
      expected_results.delete();
    end else begin
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          report("unexpected result word", '0, out_word);
        end else begin
          want = expected_results.pop_front();
          if (out_word.status !== want.status || out_word.read_value !== want.read_value ||
              out_word.item_count !== want.item_count)
            report("result mismatch", want, out_word);
        end
      end
      if (cfg_we) list_cap = cfg_wdata;
      if (start && !busy) expected_results.push_back(apply_list_op(in_word));
    end
    pending = expected_results.size();
  end

endmodule

/* tb/tb_indexed_list_insert_delete.sv */
// Testbench top: drives list operations and capacity changes, gives the verdict.
`timescale 1ns / 1ps
module tb_indexed_list_insert_delete;
  import ilid_pkg::*;

  localparam int DEPTH       = 256;
  localparam int QUIET_LIMIT = 4000;
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_word_t         in_word;
  logic             out_strobe;
  out_word_t        out_word;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;
  int               mismatches;
  int               pending;
  int               list_len;
  int               quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  indexed_list_insert_delete #(.DEPTH(DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  ilid_checker #(.DEPTH(DEPTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending),
    .list_len   (list_len)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_op(input logic [2:0] op, input int pos, input logic signed [VAL_W-1:0] val);
    in_word_t w;
    w.operation = op;
    w.position  = pos[POS_W-1:0];
    w.value     = val;
    in_word <= w;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic maybe_gap(input bit idle_ok);
    if (idle_ok && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_wdata <= cap;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_words(input int grow_pct, input int del_pct, input int n,
                              input bit idle_ok);
    logic [2:0] op;
    int         r;
    int         pos;
    repeat (n) begin
      maybe_gap(idle_ok);
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 4) op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      else if (r < grow_pct) op = ($urandom_range(0, 2) == 0) ? OP_APPEND : OP_INSERT;
      else if (r < grow_pct + del_pct) op = OP_DELETE;
      else op = ($urandom_range(0, 1) == 0) ? OP_EDIT : OP_READ;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        if (op == OP_INSERT) pos = $urandom_range(0, list_len);
        else pos = (list_len == 0) ? 0 : $urandom_range(0, list_len - 1);
      end else if (r < 90) begin
        pos = list_len + $urandom_range(0, 1);
      end else begin
        pos = $urandom_range(0, 511);
      end
      send_op(op, pos, rand_value());
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list, unknown codes, index checks, shifts at both ends
    send_op(OP_READ, 0, '0);
    send_op(OP_DELETE, 0, '0);
    send_op(OP_EDIT, 511, 32'sh7FFF_FFFF);
    for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
      send_op(op[2:0], 511, 32'sh7FFF_FFFF);
    send_op(OP_INSERT, 1, 32'sh1);
    send_op(OP_INSERT, 0, 32'sh8000_0000);
    send_op(OP_APPEND, 511, 32'sh7FFF_FFFF);
    send_op(OP_APPEND, 0, '1);
    send_op(OP_INSERT, 3, '0);
    send_op(OP_INSERT, 2, 32'sh1234_5678);
    send_op(OP_READ, 0, '0);
    send_op(OP_READ, 4, '0);
    send_op(OP_READ, 5, '0);
    send_op(OP_READ, 511, '0);
    send_op(OP_EDIT, 1, 32'shA5A5_A5A5);
    send_op(OP_EDIT, 5, 32'sh5A5A_5A5A);
    send_op(OP_READ, 1, '0);
    send_op(OP_DELETE, 0, '0);
    send_op(OP_DELETE, 3, '0);
    send_op(OP_DELETE, 3, '0);
    send_op(OP_READ, 0, '0);
    send_op(OP_READ, 2, '0);

    set_capacity('0);
    random_words(50, 30, 50, 1'b1);

    // above DEPTH: limit saturates, fill the store completely
    set_capacity('1);
    while (list_len < DEPTH) begin
      maybe_gap(1'b1);
      if ($urandom_range(0, 4) == 0) send_op(OP_INSERT, $urandom_range(0, list_len), rand_value());
      else send_op(OP_APPEND, 0, rand_value());
    end
    send_op(OP_INSERT, list_len, rand_value());
    send_op(OP_APPEND, 0, rand_value());
    send_op(OP_READ, DEPTH - 1, '0);
    send_op(OP_READ, DEPTH, '0);
    send_op(OP_EDIT, 0, rand_value());
    random_words(70, 10, 25, 1'b1);

    // capacity below the count: full, but deletes still drain
    set_capacity(9'd7);
    random_words(5, 85, 300, $urandom_range(0, 2) != 0);
    set_capacity(9'd1);
    random_words(10, 80, 150, $urandom_range(0, 2) != 0);
    set_capacity(9'd40);
    random_words(60, 20, 120, $urandom_range(0, 2) != 0);
    set_capacity(9'd300);
    random_words(55, 25, 120, $urandom_range(0, 2) != 0);
    set_capacity(9'($urandom_range(0, 511)));
    random_words(45, 30, 120, $urandom_range(0, 2) != 0);
    set_capacity(9'd2);
    random_words(40, 40, 80, $urandom_range(0, 2) != 0);
    set_capacity(CAP_RESET);
    random_words(50, 35, 150, 1'b0);

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DEPTH + 4) @(negedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
